// ===== hw/rtl/mqct_pkg.sv =====
// Package with shared types, constants and codes for the client queue tracker.
package mqct_pkg;

  localparam int MaxQueues  = 8;
  localparam int MaxClients = 32;
  localparam int KeyBits    = 16;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_MOVE  = 3'd1;
  localparam logic [2:0] CMD_QUERY = 3'd2;
  localparam logic [2:0] CMD_COUNT = 3'd3;
  localparam logic [2:0] CMD_LIST  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_QUEUE  = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] client_key;
    logic [2:0]  queue_sel;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  found_queue;
    logic [5:0]  queue_count;
    logic [15:0] listed_client;
    logic        has_client;
    logic        last;
  } rsp_t;

endpackage

// ===== hw/rtl/mqct_cell.sv =====
// One slot of the client table: holds a key and its queue, shifts down on removal.
module mqct_cell #(
  parameter int KEY_BITS = mqct_pkg::KeyBits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,   // take the upper neighbour's contents
  input  logic                load,    // take the new entry
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [2:0]          new_queue,
  input  logic                up_valid,
  input  logic [KEY_BITS-1:0] up_key,
  input  logic [2:0]          up_queue,
  output logic                valid,
  output logic [KEY_BITS-1:0] key,
  output logic [2:0]          queue
);

  // Valid flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (shift) begin
      valid <= up_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      key   <= new_key;
      queue <= new_queue;
    end else if (shift) begin
      key   <= up_key;
      queue <= up_queue;
    end
  end

endmodule

// ===== hw/rtl/multi_queue_client_tracker.sv =====
// Client queue tracker: a row of slot cells scanned by a sequencer, one slot per cycle;
// a list scan holds at each member it finds. Requests are handled one at a time: a new
// one is taken only in the idle state, after the last has loaded its result.
// The result register lets the next request enter while a result waits to be taken.
// Reset clears all slot valid flags and the fill count at once; queues_in_use resets to 8.
module multi_queue_client_tracker #(
  parameter int MAX_QUEUES  = mqct_pkg::MaxQueues,
  parameter int MAX_CLIENTS = mqct_pkg::MaxClients,
  parameter int KEY_BITS    = mqct_pkg::KeyBits
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  mqct_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output mqct_pkg::rsp_t  out_data
);

  localparam int IW = $clog2(MAX_CLIENTS);
  localparam int CW = $clog2(MAX_CLIENTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_LIST, S_EMIT
  } state_t;

  state_t              state;
  logic [3:0]          queues_in_use;
  logic [CW-1:0]       occupied_slots;
  logic [CW-1:0]       idx;
  logic [2:0]          cmd;
  logic [KEY_BITS-1:0] key;
  logic [2:0]          qsel;
  logic                found;
  logic [IW-1:0]       found_idx;
  logic [2:0]          found_q;
  logic [5:0]          count;
  logic                shifting;
  logic                pend_valid;
  mqct_pkg::rsp_t      pend;

  logic [MAX_CLIENTS-1:0] c_valid;
  logic [KEY_BITS-1:0]    c_key   [MAX_CLIENTS];
  logic [2:0]             c_queue [MAX_CLIENTS];
  logic [MAX_CLIENTS-1:0] c_shift;
  logic [MAX_CLIENTS-1:0] c_load;

  logic                qexists;
  logic [IW-1:0]       idx_i;
  logic                hit;
  logic                rsp_free;
  logic                accept;
  logic [IW-1:0]       list_slot;
  logic                list_hit;
  mqct_pkg::rsp_t      dec_rsp;
  logic                dec_write;
  logic                emit;
  mqct_pkg::rsp_t      emit_data;

  assign qexists   = ({1'b0, qsel} < queues_in_use) &&
                     ({29'd0, qsel} < 32'(MAX_QUEUES));
  assign idx_i     = idx[IW-1:0];
  assign hit       = c_valid[idx_i] && (c_key[idx_i] == key);
  assign rsp_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign list_slot = IW'(idx - CW'(1));
  assign list_hit  = c_valid[list_slot] && (c_queue[list_slot] == qsel);

  // Row of slot cells; each shifts from its upper neighbour during a removal.
  for (genvar g = 0; g < MAX_CLIENTS; g++) begin : g_cell
    logic                up_v;
    logic [KEY_BITS-1:0] up_k;
    logic [2:0]          up_q;
    if (g == MAX_CLIENTS - 1) begin : g_top
      assign up_v = 1'b0;
      assign up_k = '0;
      assign up_q = '0;
    end else begin : g_mid
      assign up_v = c_valid[g+1];
      assign up_k = c_key[g+1];
      assign up_q = c_queue[g+1];
    end
    assign c_shift[g] = shifting && (IW'(g) >= found_idx) &&
                        (CW'(g) + CW'(1) < occupied_slots);
    assign c_load[g]  = shifting && (CW'(g) + CW'(1) == occupied_slots);
    mqct_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk, .rst,
      .shift(c_shift[g]), .load(c_load[g]),
      .new_key(key), .new_queue(qsel),
      .up_valid(up_v), .up_key(up_k), .up_queue(up_q),
      .valid(c_valid[g]), .key(c_key[g]), .queue(c_queue[g])
    );
  end

  // Outcome of a scanned request and whether the slot row must be written.
  always_comb begin
    dec_rsp      = '0;
    dec_rsp.last = 1'b1;
    dec_write    = 1'b0;
    case (cmd)
      mqct_pkg::CMD_ADD: begin
        if (found) dec_rsp.status = mqct_pkg::ST_DUPLICATE;
        else if (!qexists) dec_rsp.status = mqct_pkg::ST_NO_QUEUE;
        else if (occupied_slots >= CW'(MAX_CLIENTS)) dec_rsp.status = mqct_pkg::ST_FULL;
        else begin
          dec_rsp.status = mqct_pkg::ST_OK;
          dec_write      = 1'b1;
        end
      end
      mqct_pkg::CMD_MOVE: begin
        if (!found) dec_rsp.status = mqct_pkg::ST_UNKNOWN;
        else if (!qexists) dec_rsp.status = mqct_pkg::ST_NO_QUEUE;
        else begin
          dec_rsp.status = mqct_pkg::ST_OK;
          dec_write      = (found_q != qsel);
        end
      end
      mqct_pkg::CMD_QUERY: begin
        if (!found) dec_rsp.status = mqct_pkg::ST_UNKNOWN;
        else begin
          dec_rsp.status      = mqct_pkg::ST_OK;
          dec_rsp.found_queue = found_q;
        end
      end
      default: begin
        if (!qexists) dec_rsp.status = mqct_pkg::ST_NO_QUEUE;
        else begin
          dec_rsp.status      = mqct_pkg::ST_OK;
          dec_rsp.queue_count = count;
        end
      end
    endcase
  end

  // Result to load into the output register in this cycle, if any.
  always_comb begin
    emit      = 1'b0;
    emit_data = pend;
    if (state == S_EMIT) begin
      emit = rsp_free;
    end else if (state == S_LIST) begin
      if (!qexists) begin
        emit             = rsp_free;
        emit_data        = '0;
        emit_data.status = mqct_pkg::ST_NO_QUEUE;
        emit_data.last   = 1'b1;
      end else if (idx == '0) begin
        emit = rsp_free;
        if (!pend_valid) emit_data = '0;
        emit_data.last = 1'b1;
      end else if (list_hit && pend_valid) begin
        emit = rsp_free;
      end
    end
  end

  // Sequencer with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      queues_in_use  <= 4'd8;
      occupied_slots <= '0;
      out_valid      <= 1'b0;
      pend_valid     <= 1'b0;
      shifting       <= 1'b0;
    end else begin
      if (cfg_we) queues_in_use <= cfg_data;
      if (emit) begin
        out_valid <= 1'b1;
        out_data  <= emit_data;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      shifting <= (state == S_DECIDE) && dec_write;
      unique case (state)
        S_IDLE: begin
          if (accept && in_data.cmd <= mqct_pkg::CMD_LIST) begin
            cmd   <= in_data.cmd;
            key   <= KEY_BITS'(in_data.client_key);
            qsel  <= in_data.queue_sel;
            idx   <= (in_data.cmd == mqct_pkg::CMD_LIST) ? occupied_slots : '0;
            found <= 1'b0;
            count <= '0;
            state <= (in_data.cmd == mqct_pkg::CMD_LIST) ? S_LIST : S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx >= occupied_slots) begin
            state <= S_DECIDE;
          end else begin
            if (hit && !found) begin
              found     <= 1'b1;
              found_idx <= idx_i;
              found_q   <= c_queue[idx_i];
            end
            if (c_valid[idx_i] && c_queue[idx_i] == qsel && count != 6'd63)
              count <= count + 6'd1;
            idx <= idx + CW'(1);
          end
        end
        S_DECIDE: begin
          pend       <= dec_rsp;
          pend_valid <= 1'b1;
          if (dec_write) begin
            state <= S_SHIFT;
            if (cmd == mqct_pkg::CMD_ADD) begin
              found_idx      <= occupied_slots[IW-1:0];
              occupied_slots <= occupied_slots + CW'(1);
            end
          end else begin
            state <= S_EMIT;
          end
        end
        S_SHIFT: begin
          state <= S_EMIT;
        end
        S_LIST: begin
          if (!qexists || idx == '0) begin
            if (rsp_free) begin
              pend_valid <= 1'b0;
              state      <= S_IDLE;
            end
          end else if (!list_hit) begin
            idx <= idx - CW'(1);
          end else if (pend_valid) begin
            if (rsp_free) pend_valid <= 1'b0;
          end else begin
            // Hold one found member until the next tells whether it is final.
            pend <= '{listed_client: 16'(c_key[list_slot]), has_client: 1'b1,
                      default: '0};
            pend_valid <= 1'b1;
            idx        <= idx - CW'(1);
          end
        end
        S_EMIT: begin
          if (rsp_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    occupied_slots <= CW'(MAX_CLIENTS)) else $error("fill count over capacity");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("request taken while busy");
  a_shift_once: assert property (@(posedge clk) disable iff (rst)
    shifting |=> !shifting) else $error("slot row shifted twice");
  a_load_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0(c_load)) else $error("more than one slot loaded");
`endif

endmodule
